### design/battery_soc_and_protection_top_defines.svh
// ----------------------------------------------------------------------------
// Battery SOC and protection: assertion macros
// Shared property templates, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BATTERY_SOC_AND_PROTECTION_TOP_DEFINES_SVH
`define BATTERY_SOC_AND_PROTECTION_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define BSOC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the following cycle.
`define BSOC_ASSERT_IMPLIES_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/bsoc_pkg.sv
// ----------------------------------------------------------------------------
// Battery SOC and protection package
// Field widths, register codes, state codes and the SOC curve constants.
// ----------------------------------------------------------------------------
package bsoc_pkg;

	// Cells in series in the pack
	localparam int unsigned CELLS = 2;

	// Field widths
	localparam int unsigned PACK_W     = 16;
	localparam int unsigned CUR_W      = 16;
	localparam int unsigned CUR_EXT_W  = CUR_W + 1;
	localparam int unsigned TEMP_W     = 12;
	localparam int unsigned DB_W       = 15;
	localparam int unsigned SOC_W      = 14;
	localparam int unsigned ENERGY_W   = 15;
	localparam int unsigned STATE_W    = 3;

	// Stream and configuration port widths
	localparam int unsigned IN_FIELDS_W  = PACK_W + CUR_W + TEMP_W;
	localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELDS_W = SOC_W + ENERGY_W + 2 + STATE_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned CFG_DATA_W   = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHARGE_CUTOFF    = 3'd0,
		REG_DISCHARGE_CUTOFF = 3'd1,
		REG_TEMP_MAX         = 3'd2,
		REG_TEMP_MIN         = 3'd3,
		REG_DEADBAND         = 3'd4
	} cfg_reg_t;

	typedef enum logic [STATE_W-1:0] {
		ST_IDLE        = 3'd0,
		ST_CHARGING    = 3'd1,
		ST_DISCHARGING = 3'd2,
		ST_FULL        = 3'd3,
		ST_LOW         = 3'd4,
		ST_CRITICAL    = 3'd5,
		ST_FAULT       = 3'd6
	} bat_state_t;

	// Register reset values
	localparam logic [PACK_W-1:0]        CHARGE_CUTOFF_RST    = 16'd8400;
	localparam logic [PACK_W-1:0]        DISCHARGE_CUTOFF_RST = 16'd6000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST         = 12'sd450;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN_RST         = 12'sd0;
	localparam logic [DB_W-1:0]          DEADBAND_RST         = 15'd50;

	// SOC curve, cell millivolts
	localparam int unsigned FULL_MV     = 4200;
	localparam int unsigned LOW_KNEE_MV = 3500;
	localparam logic [SOC_W-1:0] SOC_FULL = 14'd10000;
	localparam int unsigned SEGS      = 6;
	localparam int unsigned SEG_IDX_W = 3;

	// Knee compare width: pack field or the top knee in pack millivolts
	localparam int unsigned KNEE_BITS = $clog2(FULL_MV * CELLS + 1);
	localparam int unsigned KNEE_W    = (KNEE_BITS > PACK_W) ? KNEE_BITS : PACK_W;

	// Offset into a segment stays below its pack-level width (widest is 300 mV per cell).
	// A ceiling reciprocal with a shift of twice the offset width is exact there.
	localparam int unsigned SOC_DW     = $clog2(300 * CELLS);
	localparam int unsigned SOC_SHIFT  = 2 * SOC_DW;
	localparam int unsigned SOC_MW     = SOC_SHIFT + 4;
	localparam int unsigned SOC_PROD_W = SOC_SHIFT + SOC_W;

	localparam longint unsigned SEG_DEN_0 = 100 * CELLS;
	localparam longint unsigned SEG_DEN_1 = 200 * CELLS;
	localparam longint unsigned SEG_DEN_2 = 200 * CELLS;
	localparam longint unsigned SEG_DEN_3 = 200 * CELLS;
	localparam longint unsigned SEG_DEN_4 = 200 * CELLS;
	localparam longint unsigned SEG_DEN_5 = 300 * CELLS;

	localparam longint unsigned SEG_RECIP_0 =
		((64'd1000 << SOC_SHIFT) + SEG_DEN_0 - 1) / SEG_DEN_0;
	localparam longint unsigned SEG_RECIP_1 =
		((64'd2000 << SOC_SHIFT) + SEG_DEN_1 - 1) / SEG_DEN_1;
	localparam longint unsigned SEG_RECIP_2 =
		((64'd3000 << SOC_SHIFT) + SEG_DEN_2 - 1) / SEG_DEN_2;
	localparam longint unsigned SEG_RECIP_3 =
		((64'd2000 << SOC_SHIFT) + SEG_DEN_3 - 1) / SEG_DEN_3;
	localparam longint unsigned SEG_RECIP_4 =
		((64'd1500 << SOC_SHIFT) + SEG_DEN_4 - 1) / SEG_DEN_4;
	localparam longint unsigned SEG_RECIP_5 =
		((64'd500 << SOC_SHIFT) + SEG_DEN_5 - 1) / SEG_DEN_5;

	// Lower knee of a segment in pack millivolts
	function automatic logic [KNEE_W-1:0] seg_knee(input logic [SEG_IDX_W-1:0] idx);
		logic [KNEE_W-1:0] knee;
		case (idx)
			3'd0:    knee = KNEE_W'(4100 * CELLS);
			3'd1:    knee = KNEE_W'(3900 * CELLS);
			3'd2:    knee = KNEE_W'(3700 * CELLS);
			3'd3:    knee = KNEE_W'(3500 * CELLS);
			3'd4:    knee = KNEE_W'(3300 * CELLS);
			3'd5:    knee = KNEE_W'(3000 * CELLS);
			default: knee = '0;
		endcase
		return knee;
	endfunction

	function automatic logic [SOC_W-1:0] seg_base(input logic [SEG_IDX_W-1:0] idx);
		logic [SOC_W-1:0] base;
		case (idx)
			3'd0:    base = 14'd9000;
			3'd1:    base = 14'd7000;
			3'd2:    base = 14'd4000;
			3'd3:    base = 14'd2000;
			3'd4:    base = 14'd500;
			default: base = 14'd0;
		endcase
		return base;
	endfunction

	// Slope of a segment, SOC per pack millivolt, scaled by 2^SOC_SHIFT
	function automatic logic [SOC_MW-1:0] seg_recip(input logic [SEG_IDX_W-1:0] idx);
		logic [SOC_MW-1:0] recip;
		case (idx)
			3'd0:    recip = SOC_MW'(SEG_RECIP_0);
			3'd1:    recip = SOC_MW'(SEG_RECIP_1);
			3'd2:    recip = SOC_MW'(SEG_RECIP_2);
			3'd3:    recip = SOC_MW'(SEG_RECIP_3);
			3'd4:    recip = SOC_MW'(SEG_RECIP_4);
			3'd5:    recip = SOC_MW'(SEG_RECIP_5);
			default: recip = '0;
		endcase
		return recip;
	endfunction

endpackage

### design/battery_soc_and_protection_top.sv
// An accepted transaction waits in the input stage, then moves to the result register.
// Throughput: one transaction per cycle while m_axis_tready does not stall the result register.
// The input stage refills while the result register holds a stalled result.
// Reset: arst_n clears the battery state to idle and the registers to defaults.
// ----------------------------------------------------------------------------
// Battery SOC and protection top level
// Maps pack voltage to state of charge and energy, derives charge and
// discharge enables and keeps the latching battery state.
// ----------------------------------------------------------------------------
`include "battery_soc_and_protection_top_defines.svh"

module battery_soc_and_protection_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// tdata: pack_voltage_mv[15:0], current_ma[31:16], temperature_dc[43:32]
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [bsoc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// tdata: soc_centipercent[13:0], energy_mwh[28:14], charge_allowed[29],
	//        discharge_allowed[30], battery_state[33:31]
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [bsoc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [bsoc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bsoc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Configuration registers
	logic [bsoc_pkg::PACK_W-1:0]        charge_cutoff_q;
	logic [bsoc_pkg::PACK_W-1:0]        discharge_cutoff_q;
	logic signed [bsoc_pkg::TEMP_W-1:0] temp_max_q;
	logic signed [bsoc_pkg::TEMP_W-1:0] temp_min_q;
	logic [bsoc_pkg::DB_W-1:0]          deadband_q;

	// Input stage
	logic                               valid_s1;
	logic [bsoc_pkg::PACK_W-1:0]        pack_s1;
	logic signed [bsoc_pkg::CUR_W-1:0]  cur_s1;
	logic signed [bsoc_pkg::TEMP_W-1:0] temp_s1;

	// Result register
	logic                               m_valid_q;
	logic [bsoc_pkg::SOC_W-1:0]         soc_q;
	logic [bsoc_pkg::ENERGY_W-1:0]      energy_q;
	logic                               chg_q;
	logic                               dis_q;
	bsoc_pkg::bat_state_t               state_q;

	logic s_accept;
	logic advance;

	// SOC datapath
	logic [bsoc_pkg::KNEE_W-1:0]     p_ext;
	logic [bsoc_pkg::SEG_IDX_W-1:0]  seg_sel;
	logic                            seg_hit;
	logic                            curve_full;
	logic [bsoc_pkg::KNEE_W-1:0]     seg_diff;
	logic [bsoc_pkg::SOC_DW-1:0]     seg_d;
	logic [bsoc_pkg::SOC_PROD_W-1:0] seg_prod;
	logic [bsoc_pkg::SOC_W-1:0]      seg_frac;
	logic [bsoc_pkg::SOC_W-1:0]      soc_c;
	logic [bsoc_pkg::ENERGY_W-1:0]   energy_c;

	// Protection and state
	logic                                  at_full;
	logic                                  at_empty;
	logic                                  temp_bad;
	logic                                  soc_low;
	logic signed [bsoc_pkg::CUR_EXT_W-1:0] cur_ext;
	logic signed [bsoc_pkg::CUR_EXT_W-1:0] db_ext;
	logic                                  cur_pos;
	logic                                  cur_neg;
	logic                                  has_ev;
	logic                                  state_latched;
	bsoc_pkg::bat_state_t                  ev_state;
	bsoc_pkg::bat_state_t                  state_nxt;

	function automatic logic [1:0] state_rank(input bsoc_pkg::bat_state_t st);
		logic [1:0] rank;
		case (st)
			bsoc_pkg::ST_FAULT:    rank = 2'd3;
			bsoc_pkg::ST_CRITICAL: rank = 2'd2;
			bsoc_pkg::ST_FULL:     rank = 2'd1;
			default:               rank = 2'd0;
		endcase
		return rank;
	endfunction

	// Handshake: the input stage moves on whenever the result slot is free or drains
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_cutoff_q    <= bsoc_pkg::CHARGE_CUTOFF_RST;
			discharge_cutoff_q <= bsoc_pkg::DISCHARGE_CUTOFF_RST;
			temp_max_q         <= bsoc_pkg::TEMP_MAX_RST;
			temp_min_q         <= bsoc_pkg::TEMP_MIN_RST;
			deadband_q         <= bsoc_pkg::DEADBAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bsoc_pkg::REG_CHARGE_CUTOFF: begin
					charge_cutoff_q <= cfg_data[bsoc_pkg::PACK_W-1:0];
				end
				bsoc_pkg::REG_DISCHARGE_CUTOFF: begin
					discharge_cutoff_q <= cfg_data[bsoc_pkg::PACK_W-1:0];
				end
				bsoc_pkg::REG_TEMP_MAX: begin
					temp_max_q <= $signed(cfg_data[bsoc_pkg::TEMP_W-1:0]);
				end
				bsoc_pkg::REG_TEMP_MIN: begin
					temp_min_q <= $signed(cfg_data[bsoc_pkg::TEMP_W-1:0]);
				end
				bsoc_pkg::REG_DEADBAND: begin
					deadband_q <= cfg_data[bsoc_pkg::DB_W-1:0];
				end
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pack_s1 <= s_axis_tdata[0 +: bsoc_pkg::PACK_W];
			cur_s1  <= $signed(s_axis_tdata[bsoc_pkg::PACK_W +: bsoc_pkg::CUR_W]);
			temp_s1 <= $signed(s_axis_tdata[bsoc_pkg::PACK_W + bsoc_pkg::CUR_W +:
				bsoc_pkg::TEMP_W]);
		end
	end

	// Segment search: lower knees fall with the index, so the last hit is the highest knee
	assign p_ext = bsoc_pkg::KNEE_W'(pack_s1);

	always_comb begin
		seg_sel = '0;
		seg_hit = 1'b0;
		for (int i = bsoc_pkg::SEGS - 1; i >= 0; i--) begin
			if (p_ext >= bsoc_pkg::seg_knee(bsoc_pkg::SEG_IDX_W'(i))) begin
				seg_sel = bsoc_pkg::SEG_IDX_W'(i);
				seg_hit = 1'b1;
			end
		end
	end

	assign curve_full = p_ext >= bsoc_pkg::KNEE_W'(bsoc_pkg::FULL_MV * bsoc_pkg::CELLS);
	assign seg_diff   = p_ext - bsoc_pkg::seg_knee(seg_sel);
	assign seg_d      = seg_diff[bsoc_pkg::SOC_DW-1:0];
	assign seg_prod   = bsoc_pkg::SOC_PROD_W'(seg_d) *
		bsoc_pkg::SOC_PROD_W'(bsoc_pkg::seg_recip(seg_sel));
	assign seg_frac   = seg_prod[bsoc_pkg::SOC_SHIFT +: bsoc_pkg::SOC_W];

	always_comb begin
		if (curve_full) begin
			soc_c = bsoc_pkg::SOC_FULL;
		end else if (seg_hit) begin
			soc_c = bsoc_pkg::seg_base(seg_sel) + seg_frac;
		end else begin
			soc_c = '0;
		end
	end

	assign energy_c = bsoc_pkg::ENERGY_W'(soc_c) + bsoc_pkg::ENERGY_W'({soc_c, 1'b0});

	// SOC falls under 20 percent exactly below the 3500 mV cell knee
	assign soc_low  = p_ext < bsoc_pkg::KNEE_W'(bsoc_pkg::LOW_KNEE_MV * bsoc_pkg::CELLS);
	assign at_full  = pack_s1 >= charge_cutoff_q;
	assign at_empty = pack_s1 <= discharge_cutoff_q;
	assign temp_bad = (temp_s1 > temp_max_q) || (temp_s1 < temp_min_q);

	assign cur_ext = {cur_s1[bsoc_pkg::CUR_W-1], cur_s1};
	assign db_ext  = $signed({2'b00, deadband_q});
	assign cur_pos = cur_ext > db_ext;
	assign cur_neg = cur_ext < -db_ext;

	assign state_latched = state_q inside {bsoc_pkg::ST_FULL, bsoc_pkg::ST_CRITICAL,
		bsoc_pkg::ST_FAULT};

	always_comb begin
		has_ev   = 1'b1;
		ev_state = bsoc_pkg::ST_IDLE;
		if (temp_bad) begin
			ev_state = bsoc_pkg::ST_FAULT;
		end else if (at_empty) begin
			ev_state = bsoc_pkg::ST_CRITICAL;
		end else if (at_full) begin
			ev_state = bsoc_pkg::ST_FULL;
		end else begin
			has_ev = 1'b0;
		end

		if (state_latched) begin
			// latched: only escalate
			state_nxt = state_q;
			if (has_ev && (state_rank(ev_state) > state_rank(state_q))) begin
				state_nxt = ev_state;
			end
		end else if (has_ev) begin
			state_nxt = ev_state;
		end else if (soc_low) begin
			state_nxt = bsoc_pkg::ST_LOW;
		end else if (cur_pos) begin
			state_nxt = bsoc_pkg::ST_CHARGING;
		end else if (cur_neg) begin
			state_nxt = bsoc_pkg::ST_DISCHARGING;
		end else begin
			state_nxt = bsoc_pkg::ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			state_q   <= bsoc_pkg::ST_IDLE;
		end else if (advance) begin
			m_valid_q <= 1'b1;
			state_q   <= state_nxt;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			soc_q    <= soc_c;
			energy_q <= energy_c;
			chg_q    <= !at_full && !temp_bad;
			dis_q    <= !at_empty;
		end
	end

	// The battery state field is the state register itself; it only moves with a new result
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{bsoc_pkg::OUT_PAD_W{1'b0}}, state_q, dis_q, chg_q, energy_q, soc_q};

	`BSOC_ASSERT_IMPLIES_NEXT(a_latch_holds, state_latched, state_latched, "latched battery state fell back")
	`BSOC_ASSERT_IMPLIES_NEXT(a_fault_sticky, state_q == bsoc_pkg::ST_FAULT, state_q == bsoc_pkg::ST_FAULT, "fault state left")
	`BSOC_ASSERT_IMPLIES_NEXT(a_state_on_advance, !advance, $stable(state_q), "battery state changed without a transaction")
	`BSOC_ASSERT_IMPLIES(a_soc_range, m_valid_q, soc_q <= bsoc_pkg::SOC_FULL, "state of charge above full scale")

endmodule

### test/battery_reading_checker.sv
// ----------------------------------------------------------------------------
// Battery reading checker
// Watches the measurement and status streams and the register port, predicts
// SOC, energy, enables and battery state per measurement, and compares each
// status transaction against the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module battery_reading_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [bsoc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [bsoc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [bsoc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsoc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatch_count,
	output int                               status_outstanding
);
	import bsoc_pkg::*;

	localparam int unsigned LOW_SOC = 2000;

	// Highest field first, as packed on m_axis_tdata
	typedef struct packed {
		logic [STATE_W-1:0]  state;
		logic                dis_ok;
		logic                chg_ok;
		logic [ENERGY_W-1:0] energy;
		logic [SOC_W-1:0]    soc;
	} reading_status_t;

	logic [PACK_W-1:0]        chg_cut;
	logic [PACK_W-1:0]        dis_cut;
	logic signed [TEMP_W-1:0] temp_max;
	logic signed [TEMP_W-1:0] temp_min;
	logic [DB_W-1:0]          deadband;
	bat_state_t               batt_state;

	reading_status_t reading_status_q[$];
	reading_status_t got;
	reading_status_t want;

	function automatic logic [SOC_W-1:0] soc_from_pack(input logic [PACK_W-1:0] pv);
		int unsigned p;
		int unsigned c;
		p = pv;
		c = CELLS;
		if (p >= 4200 * c) return SOC_W'(10000);
		if (p >= 4100 * c) return SOC_W'(9000 + (p - 4100 * c) * 1000 / (100 * c));
		if (p >= 3900 * c) return SOC_W'(7000 + (p - 3900 * c) * 2000 / (200 * c));
		if (p >= 3700 * c) return SOC_W'(4000 + (p - 3700 * c) * 3000 / (200 * c));
		if (p >= 3500 * c) return SOC_W'(2000 + (p - 3500 * c) * 2000 / (200 * c));
		if (p >= 3300 * c) return SOC_W'(500 + (p - 3300 * c) * 1500 / (200 * c));
		if (p >= 3000 * c) return SOC_W'((p - 3000 * c) * 500 / (300 * c));
		return '0;
	endfunction

	// Only full, critical and fault latch; higher severity wins
	function automatic int severity(input bat_state_t s);
		case (s)
			ST_FAULT:    return 3;
			ST_CRITICAL: return 2;
			ST_FULL:     return 1;
			default:     return 0;
		endcase
	endfunction

	function automatic reading_status_t assess_reading(input logic [IN_TDATA_W-1:0] d);
		logic [PACK_W-1:0]        pv;
		logic signed [CUR_W-1:0]  cur;
		logic signed [TEMP_W-1:0] temp;
		logic [SOC_W-1:0]         soc;
		logic                     over_v;
		logic                     under_v;
		logic                     temp_bad;
		logic                     has_event;
		bat_state_t               evt;
		bat_state_t               nxt;
		int                       cur_i;
		int                       db_i;
		reading_status_t          r;
		pv = d[PACK_W-1:0];
		cur = d[PACK_W +: CUR_W];
		temp = d[PACK_W+CUR_W +: TEMP_W];
		soc = soc_from_pack(pv);
		over_v = pv >= chg_cut;
		under_v = pv <= dis_cut;
		temp_bad = (temp > temp_max) || (temp < temp_min);
		has_event = 1'b1;
		evt = ST_IDLE;
		if (temp_bad) evt = ST_FAULT;
		else if (under_v) evt = ST_CRITICAL;
		else if (over_v) evt = ST_FULL;
		else has_event = 1'b0;
		cur_i = cur;
		db_i = deadband;
		if (severity(batt_state) != 0) begin
			nxt = batt_state;
			if (has_event && severity(evt) > severity(batt_state)) nxt = evt;
		end else if (has_event) begin
			nxt = evt;
		end else begin
			if (cur_i > db_i) nxt = ST_CHARGING;
			else if (cur_i < -db_i) nxt = ST_DISCHARGING;
			else nxt = ST_IDLE;
			if (soc < LOW_SOC) nxt = ST_LOW;
		end
		batt_state = nxt;
		r.soc = soc;
		r.energy = ENERGY_W'(soc * 3);
		r.chg_ok = !over_v && !temp_bad;
		r.dis_ok = !under_v;
		r.state = nxt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chg_cut = CHARGE_CUTOFF_RST;
			dis_cut = DISCHARGE_CUTOFF_RST;
			temp_max = TEMP_MAX_RST;
			temp_min = TEMP_MIN_RST;
			deadband = DEADBAND_RST;
			batt_state = ST_IDLE;
			reading_status_q.delete();
			mismatch_count = 0;
			status_outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = reading_status_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
				if (reading_status_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected status transaction: soc %0d energy %0d chg %b dis %b state %0d",
							got.soc, got.energy, got.chg_ok, got.dis_ok, got.state);
				end else begin
					want = reading_status_q.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("status mismatch exp/act: soc %0d/%0d energy %0d/%0d chg %b/%b dis %b/%b state %0d/%0d",
								want.soc, got.soc, want.energy, got.energy, want.chg_ok, got.chg_ok,
								want.dis_ok, got.dis_ok, want.state, got.state);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				reading_status_q.push_back(assess_reading(s_axis_tdata));
			// Apply register writes after the prediction of this edge
			if (cfg_we) begin
				case (cfg_index)
					REG_CHARGE_CUTOFF:    chg_cut = cfg_data;
					REG_DISCHARGE_CUTOFF: dis_cut = cfg_data;
					REG_TEMP_MAX:         temp_max = cfg_data[TEMP_W-1:0];
					REG_TEMP_MIN:         temp_min = cfg_data[TEMP_W-1:0];
					REG_DEADBAND:         deadband = cfg_data[DB_W-1:0];
					default: ;
				endcase
			end
			status_outstanding = reading_status_q.size();
		end
	end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Battery SOC and protection testbench
// Drives directed and random measurements through several register settings,
// with random idling on both streams, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
	import bsoc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {
		GEN_CALM,   // only extreme voltage codes avoided; no event under widest limits
		GEN_SAFE,   // voltage between cutoffs, temperature within limits
		GEN_VOLT,   // any voltage, temperature within limits
		GEN_ANY
	} gen_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]   m_axis_tdata;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;

	int mismatch_count;
	int status_outstanding;
	int cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	logic held_off = 1'b0;

	// Register settings as last written, for shaping the stimulus
	int lim_chg = CHARGE_CUTOFF_RST;
	int lim_dis = DISCHARGE_CUTOFF_RST;
	int lim_tmax = TEMP_MAX_RST;
	int lim_tmin = TEMP_MIN_RST;
	int lim_db = DEADBAND_RST;

	battery_soc_and_protection_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	battery_reading_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.s_axis_tvalid      (s_axis_tvalid),
		.s_axis_tready      (s_axis_tready),
		.s_axis_tdata       (s_axis_tdata),
		.m_axis_tvalid      (m_axis_tvalid),
		.m_axis_tready      (m_axis_tready),
		.m_axis_tdata       (m_axis_tdata),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mismatch_count     (mismatch_count),
		.status_outstanding (status_outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) results_seen++;
	end

	// Status side: one long hold-off early on, then random stalls except in a stall-free window
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && results_seen >= 40) begin
				m_axis_tready <= 1'b0;
				for (hold = 0; hold < 80; hold++) @(negedge clk);
				held_off = 1'b1;
			end
			m_axis_tready <= (results_seen >= 250 && results_seen < 400) ||
				($urandom_range(99) >= 29);
		end
	end

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
	endtask

	// Write every register, with junk above the field widths, plus the unused indexes
	task automatic set_limits(input int chg, input int dis, input int tmax, input int tmin,
		input int db);
		int i;
		lim_chg = chg;
		lim_dis = dis;
		lim_tmax = tmax;
		lim_tmin = tmin;
		lim_db = db;
		set_reg(REG_CHARGE_CUTOFF, 16'(chg));
		set_reg(REG_DISCHARGE_CUTOFF, 16'(dis));
		set_reg(REG_TEMP_MAX, {4'($urandom), 12'(tmax)});
		set_reg(REG_TEMP_MIN, {4'($urandom), 12'(tmin)});
		set_reg(REG_DEADBAND, {1'($urandom), 15'(db)});
		for (i = REG_DEADBAND + 1; i < 2 ** CFG_IDX_W; i++)
			set_reg(CFG_IDX_W'(i), 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic send_reading(input logic [PACK_W-1:0] pv, input logic signed [CUR_W-1:0] cur,
		input logic signed [TEMP_W-1:0] temp);
		while (!(items_sent >= 250 && items_sent < 400) && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, temp, cur, pv};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Hold the input idle until every status transaction has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (status_outstanding != 0) @(negedge clk);
	endtask

	function automatic logic [PACK_W-1:0] pick_pack();
		int r;
		int knee;
		r = $urandom_range(99);
		if (r < 55) return PACK_W'($urandom_range(8600, 5800));
		if (r < 75) begin
			case ($urandom_range(6))
				0:       knee = 4200;
				1:       knee = 4100;
				2:       knee = 3900;
				3:       knee = 3700;
				4:       knee = 3500;
				5:       knee = 3300;
				default: knee = 3000;
			endcase
			return PACK_W'(knee * CELLS + int'($urandom_range(4)) - 2);
		end
		return PACK_W'($urandom);
	endfunction

	function automatic logic signed [CUR_W-1:0] pick_current();
		int r;
		int c;
		r = $urandom_range(99);
		if (r < 35) begin
			c = int'($urandom_range(65535)) - 32768;
		end else if (r < 70) begin
			// straddle the deadband on either side
			c = lim_db + int'($urandom_range(2)) - 1;
			if ($urandom_range(1) == 1) c = -c;
		end else begin
			c = int'($urandom_range(400)) - 200;
		end
		return CUR_W'(c);
	endfunction

	function automatic logic signed [TEMP_W-1:0] pick_temp(input logic in_limits);
		int r;
		if (in_limits) return TEMP_W'(lim_tmin + int'($urandom_range(lim_tmax - lim_tmin)));
		r = $urandom_range(99);
		if (r < 50) return TEMP_W'(int'($urandom_range(2500)) - 1000);
		if (r < 75) return TEMP_W'(((r < 62) ? lim_tmax : lim_tmin) + int'($urandom_range(2)) - 1);
		return TEMP_W'($urandom);
	endfunction

	task automatic run_batch(input int n, input gen_mode_t mode);
		int i;
		logic [PACK_W-1:0] pv;
		for (i = 0; i < n; i++) begin
			pv = pick_pack();
			case (mode)
				GEN_CALM: begin
					if (pv == '0) pv = 1;
					else if (pv == '1) pv = pv - 1;
				end
				GEN_SAFE: while (int'(pv) <= lim_dis || int'(pv) >= lim_chg) pv = pick_pack();
				default: ;
			endcase
			send_reading(pv, pick_current(), pick_temp(mode == GEN_SAFE || mode == GEN_VOLT));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: curve knees, deadband edges, current extremes
		send_reading(8399, 51, 450);
		send_reading(8200, -51, 0);
		send_reading(8199, 50, 200);
		send_reading(7800, -50, 200);
		send_reading(7400, 32767, 100);
		send_reading(7000, -32768, 100);
		send_reading(6999, 0, 100);
		send_reading(6600, 100, 100);
		send_reading(6001, -100, 300);
		send_reading(7500, 0, 449);
		run_batch(150, GEN_SAFE);
		drain();

		// Widest limits: only the extreme voltage codes could cause an event
		set_limits(16'hFFFF, 0, 2047, -2048, 0);
		send_reading(1, 0, -2048);
		send_reading(5999, 1, 2047);
		send_reading(6000, -1, 0);
		send_reading(8400, 1, 0);
		send_reading(65534, -1, 0);
		send_reading(16'h8000, 0, 0);
		run_batch(200, GEN_CALM);
		drain();
		set_limits(16'hFFFF, 0, 2047, -2048, 32767);
		run_batch(150, GEN_CALM);
		drain();
		set_limits(16'hFFFF, 0, 2047, -2048, $urandom_range(2000));
		run_batch(150, GEN_CALM);
		drain();

		// Latching: reach full, stay there at the limit edges, then random voltages can escalate
		set_limits(7600, 6400, 450, -100, 100);
		run_batch(80, GEN_SAFE);
		send_reading(7600, 0, 450);
		send_reading(7599, 500, -100);
		send_reading(6401, -500, 0);
		run_batch(60, GEN_VOLT);
		drain();
		// Cutoffs overlap: critical wins, both enables drop
		set_limits(6000, 7000, 450, -100, 100);
		send_reading(6500, 0, 0);
		send_reading(7200, 0, 0);
		send_reading(5000, 0, 451);
		run_batch(60, GEN_ANY);
		drain();
		// Crossed temperature limits
		set_limits(6000, 7000, 100, 500, 100);
		run_batch(40, GEN_ANY);
		drain();
		set_limits(0, 65535, 1500, -1000, 32767);
		run_batch(40, GEN_ANY);
		drain();
		set_limits(65535, 0, 1500, -1000, 0);
		run_batch(40, GEN_ANY);
		drain();

		repeat (4) @(negedge clk);
		if (mismatch_count == 0 && status_outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
